>>> rtl/core/emc_pkg.sv
// Shared widths, divisor constants, stage interface structs and the
// month-start table for the epoch-millis to calendar converter.
// No dependencies.
package emc_pkg;

    localparam int TIME_BITS = 45;
    localparam int S_TDATA_W = ((TIME_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W = 48;

    // Time split: ms-of-day is carried as 1024-ms units plus the low 10 bits
    localparam int SUB_MS_W = 10;
    localparam int X_W      = TIME_BITS - SUB_MS_W;
    localparam int XLO_W    = 15;
    localparam int XHI_W    = X_W - XLO_W;
    localparam int QHI_W    = (TIME_BITS > 42) ? TIME_BITS - 41 : 1;
    localparam int DAY_W    = QHI_W + XLO_W;
    localparam int MSD_W    = 27;
    localparam int Q400_W   = (DAY_W > 18) ? DAY_W - 17 : 1;

    localparam logic [TIME_BITS-1:0] MS_AT_2000 = TIME_BITS'(64'd946684800000);

    localparam logic [16:0] DAY_UNITS  = 17'd84375;   // 86400000 / 1024
    localparam logic [15:0] DAY_RECIP  = 16'd50903;   // floor(2^32 / 84375)
    localparam logic [6:0]  SEC_UNITS  = 7'd125;      // 1000 / 8
    localparam logic [17:0] SEC_RECIP  = 18'd134217;  // floor(2^24 / 125)
    localparam logic [7:0]  HOUR_UNITS = 8'd225;      // 3600 / 16
    localparam logic [3:0]  MIN_UNITS  = 4'd15;       // 60 / 4

    localparam logic [17:0] DAYS_400Y      = 18'd146097;
    localparam logic [15:0] DAYS_100Y      = 16'd36524;
    localparam logic [15:0] DAYS_100Y_LEAP = 16'd36525;
    localparam logic [10:0] DAYS_4Y        = 11'd1461;
    localparam logic [10:0] DAYS_4Y_COMMON = 11'd1460;
    localparam logic [10:0] DAYS_YEAR      = 11'd365;
    localparam logic [10:0] DAYS_LEAP_YEAR = 11'd366;
    localparam logic [11:0] YEAR_BASE      = 12'd2000;

    localparam logic [8:0] LEAP_DAY_DOY   = 9'd59;
    localparam logic [3:0] MONTH_FEB      = 4'd1;
    localparam logic [4:0] LEAP_DAY_INDEX = 5'd28;

    typedef struct packed {
        logic [DAY_W-1:0] day;
        logic [MSD_W-1:0] msd;
    } day_split_t;

    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
        logic [9:0] millis;
    } clock_t;

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
    } date_t;

    function automatic logic [8:0] month_start(input logic [3:0] month);
        logic [8:0] start;
        unique case (month)
            4'd0:    start = 9'd0;
            4'd1:    start = 9'd31;
            4'd2:    start = 9'd59;
            4'd3:    start = 9'd90;
            4'd4:    start = 9'd120;
            4'd5:    start = 9'd151;
            4'd6:    start = 9'd181;
            4'd7:    start = 9'd212;
            4'd8:    start = 9'd243;
            4'd9:    start = 9'd273;
            4'd10:   start = 9'd304;
            4'd11:   start = 9'd334;
            default: start = 9'd0;
        endcase
        return start;
    endfunction

endpackage

>>> rtl/core/emc_day_split.sv
// Five-stage split of a millisecond timestamp into days since 2000-01-01
// and milliseconds of the day. Depends on emc_pkg.
module emc_day_split (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic [emc_pkg::TIME_BITS-1:0]     in_millis,
    output logic                              out_valid,
    output emc_pkg::day_split_t               out_split
);

    logic [4:0] valid_reg;

    logic [emc_pkg::TIME_BITS-1:0] v1_reg, v1_next;

    logic [emc_pkg::QHI_W-1:0]     qhi2_reg, qhi2_next;
    logic [31:0]                   x2_reg, x2_next;
    logic [emc_pkg::SUB_MS_W-1:0]  ms2_reg;

    logic [47:0]                   prod3;
    logic [emc_pkg::QHI_W-1:0]     qhi3_reg;
    logic [31:0]                   x3_reg;
    logic [14:0]                   qlo3_reg;
    logic [emc_pkg::SUB_MS_W-1:0]  ms3_reg;

    logic [31:0]                   qd4;
    logic [31:0]                   diff4;
    logic [emc_pkg::QHI_W-1:0]     qhi4_reg;
    logic [14:0]                   qlo4_reg;
    logic [17:0]                   r4_reg;
    logic [emc_pkg::SUB_MS_W-1:0]  ms4_reg;

    logic                          fix5;
    logic [17:0]                   r5;
    logic [emc_pkg::DAY_W-1:0]     day5_reg, day5_next;
    logic [emc_pkg::MSD_W-1:0]     msd5_reg, msd5_next;

    // stage 1: clamp to 2000-01-01 and rebase
    assign v1_next = (in_millis < emc_pkg::MS_AT_2000) ? '0
                                                       : in_millis - emc_pkg::MS_AT_2000;

    // stage 2: high digit of the long division by 84375
    always_comb begin
        logic [emc_pkg::XHI_W:0] rem;
        rem       = {1'b0, v1_reg[emc_pkg::TIME_BITS-1 -: emc_pkg::XHI_W]};
        qhi2_next = '0;
        for (int i = emc_pkg::QHI_W - 1; i >= 0; i--) begin
            if (rem >= ((emc_pkg::XHI_W + 1)'(emc_pkg::DAY_UNITS) << i)) begin
                rem          = rem - ((emc_pkg::XHI_W + 1)'(emc_pkg::DAY_UNITS) << i);
                qhi2_next[i] = 1'b1;
            end
        end
        x2_next = {rem[16:0], v1_reg[emc_pkg::SUB_MS_W +: emc_pkg::XLO_W]};
    end

    // stage 3: reciprocal estimate of the low digit, at most one short
    assign prod3 = x2_reg * emc_pkg::DAY_RECIP;

    // stage 4: remainder of the estimate, below twice the divisor
    assign qd4   = qlo3_reg * emc_pkg::DAY_UNITS;
    assign diff4 = x3_reg - qd4;

    // stage 5: correction
    assign fix5      = r4_reg >= {1'b0, emc_pkg::DAY_UNITS};
    assign r5        = fix5 ? r4_reg - {1'b0, emc_pkg::DAY_UNITS} : r4_reg;
    assign day5_next = {qhi4_reg, qlo4_reg + 15'(fix5)};
    assign msd5_next = {r5[16:0], ms4_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[3:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            v1_reg   <= v1_next;
            qhi2_reg <= qhi2_next;
            x2_reg   <= x2_next;
            ms2_reg  <= v1_reg[emc_pkg::SUB_MS_W-1:0];
            qhi3_reg <= qhi2_reg;
            x3_reg   <= x2_reg;
            qlo3_reg <= prod3[46:32];
            ms3_reg  <= ms2_reg;
            qhi4_reg <= qhi3_reg;
            qlo4_reg <= qlo3_reg;
            r4_reg   <= diff4[17:0];
            ms4_reg  <= ms3_reg;
            day5_reg <= day5_next;
            msd5_reg <= msd5_next;
        end
    end

    assign out_valid     = valid_reg[4];
    assign out_split.day = day5_reg;
    assign out_split.msd = msd5_reg;

endmodule

>>> rtl/core/emc_clock_split.sv
// Five-stage split of milliseconds of the day into hour, minute, second
// and millisecond. Depends on emc_pkg.
module emc_clock_split (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [emc_pkg::MSD_W-1:0]     in_msd,
    output logic                          out_valid,
    output emc_pkg::clock_t               out_clock
);

    logic [4:0] valid_reg;

    logic [41:0] prod1;
    logic [23:0] x1_reg;
    logic [16:0] q1_reg;
    logic [2:0]  lo1_reg;

    logic [23:0] qm2;
    logic [23:0] diff2;
    logic [16:0] q2_reg;
    logic [7:0]  r2_reg;
    logic [2:0]  lo2_reg;

    logic        fix3;
    logic [7:0]  r3;
    logic [16:0] sod3_reg;
    logic [9:0]  ms3_reg, ms3_next;

    logic [4:0]  hr4_reg, hr4_next;
    logic [11:0] soh4_reg, soh4_next;
    logic [9:0]  ms4_reg;

    logic [4:0]  hr5_reg;
    logic [5:0]  min5_reg, min5_next;
    logic [5:0]  sec5_reg, sec5_next;
    logic [9:0]  ms5_reg;

    // stage 1: seconds estimate, (msd / 8) / 125
    assign prod1 = in_msd[emc_pkg::MSD_W-1:3] * emc_pkg::SEC_RECIP;

    // stage 2: remainder of the estimate
    assign qm2   = q1_reg * emc_pkg::SEC_UNITS;
    assign diff2 = x1_reg - qm2;

    // stage 3: correction
    assign fix3     = r2_reg >= {1'b0, emc_pkg::SEC_UNITS};
    assign r3       = fix3 ? r2_reg - {1'b0, emc_pkg::SEC_UNITS} : r2_reg;
    assign ms3_next = {r3[6:0], lo2_reg};

    // stage 4: hour, (sod / 16) / 225
    always_comb begin
        logic [12:0] rem;
        rem      = sod3_reg[16:4];
        hr4_next = '0;
        for (int i = 4; i >= 0; i--) begin
            if (rem >= (13'(emc_pkg::HOUR_UNITS) << i)) begin
                rem         = rem - (13'(emc_pkg::HOUR_UNITS) << i);
                hr4_next[i] = 1'b1;
            end
        end
        soh4_next = {rem[7:0], sod3_reg[3:0]};
    end

    // stage 5: minute, (soh / 4) / 15
    always_comb begin
        logic [9:0] rem;
        rem       = soh4_reg[11:2];
        min5_next = '0;
        for (int i = 5; i >= 0; i--) begin
            if (rem >= (10'(emc_pkg::MIN_UNITS) << i)) begin
                rem          = rem - (10'(emc_pkg::MIN_UNITS) << i);
                min5_next[i] = 1'b1;
            end
        end
        sec5_next = {rem[3:0], soh4_reg[1:0]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[3:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x1_reg   <= in_msd[emc_pkg::MSD_W-1:3];
            q1_reg   <= prod1[40:24];
            lo1_reg  <= in_msd[2:0];
            q2_reg   <= q1_reg;
            r2_reg   <= diff2[7:0];
            lo2_reg  <= lo1_reg;
            sod3_reg <= q2_reg + 17'(fix3);
            ms3_reg  <= ms3_next;
            hr4_reg  <= hr4_next;
            soh4_reg <= soh4_next;
            ms4_reg  <= ms3_reg;
            hr5_reg  <= hr4_reg;
            min5_reg <= min5_next;
            sec5_reg <= sec5_next;
            ms5_reg  <= ms4_reg;
        end
    end

    assign out_valid        = valid_reg[4];
    assign out_clock.hour   = hr5_reg;
    assign out_clock.minute = min5_reg;
    assign out_clock.second = sec5_reg;
    assign out_clock.millis = ms5_reg;

endmodule

>>> rtl/core/emc_date_split.sv
// Five-stage Gregorian date from days since 2000-01-01: 400/100/4/1-year
// blocks, then the month-start table. Depends on emc_pkg.
module emc_date_split (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [emc_pkg::DAY_W-1:0]     in_day,
    output logic                          out_valid,
    output emc_pkg::date_t                out_date
);

    logic [4:0] valid_reg;

    logic [emc_pkg::Q400_W-1:0] q400_1_reg, q400_1_next;
    logic [17:0]                r1_reg, r1_next;

    logic [emc_pkg::Q400_W-1:0] q400_2_reg;
    logic [1:0]                 cent2_reg, cent2_next;
    logic                       bump2_reg, bump2_next;
    logic                       fl2_reg, fl2_next;
    logic [15:0]                u2_reg, u2_next;

    logic [emc_pkg::Q400_W-1:0] q400_3_reg;
    logic [1:0]                 cent3_reg;
    logic                       bump3_reg;
    logic                       fl3_reg;
    logic [4:0]                 q4_3_reg, q4_3_next;
    logic [10:0]                r4_3_reg, r4_3_next;

    logic [11:0]                year4_reg, year4_next;
    logic [8:0]                 doy4_reg, doy4_next;
    logic                       leap4_reg, leap4_next;

    logic [11:0]                year5_reg;
    logic [3:0]                 month5_reg, month5_next;
    logic [4:0]                 day5_reg, day5_next;

    // stage 1: 400-year blocks
    always_comb begin
        logic [emc_pkg::DAY_W:0] rem;
        rem         = {1'b0, in_day};
        q400_1_next = '0;
        for (int i = emc_pkg::Q400_W - 1; i >= 0; i--) begin
            if (rem >= ((emc_pkg::DAY_W + 1)'(emc_pkg::DAYS_400Y) << i)) begin
                rem            = rem - ((emc_pkg::DAY_W + 1)'(emc_pkg::DAYS_400Y) << i);
                q400_1_next[i] = 1'b1;
            end
        end
        r1_next = rem[17:0];
    end

    // stage 2: centuries; a common century year shortens the first 4-year group
    always_comb begin
        logic [16:0] rem;
        logic [1:0]  cq;
        logic [15:0] r2;
        rem = '0;
        cq  = '0;
        if (r1_reg < 18'(emc_pkg::DAYS_100Y_LEAP)) begin
            r2         = r1_reg[15:0];
            cent2_next = '0;
        end else begin
            rem = 17'(r1_reg - 18'(emc_pkg::DAYS_100Y_LEAP));
            for (int i = 1; i >= 0; i--) begin
                if (rem >= (17'(emc_pkg::DAYS_100Y) << i)) begin
                    rem   = rem - (17'(emc_pkg::DAYS_100Y) << i);
                    cq[i] = 1'b1;
                end
            end
            r2         = rem[15:0];
            cent2_next = cq + 2'd1;
        end
        bump2_next = (cent2_next != 2'd0) && (r2 >= 16'(emc_pkg::DAYS_4Y_COMMON));
        u2_next    = bump2_next ? r2 - 16'(emc_pkg::DAYS_4Y_COMMON) : r2;
        fl2_next   = (cent2_next == 2'd0) || bump2_next;
    end

    // stage 3: 4-year groups
    always_comb begin
        logic [15:0] rem;
        rem       = u2_reg;
        q4_3_next = '0;
        for (int i = 4; i >= 0; i--) begin
            if (rem >= (16'(emc_pkg::DAYS_4Y) << i)) begin
                rem          = rem - (16'(emc_pkg::DAYS_4Y) << i);
                q4_3_next[i] = 1'b1;
            end
        end
        r4_3_next = rem[10:0];
    end

    // stage 4: year in group, day of year, year number
    always_comb begin
        logic [10:0]                first_len;
        logic [10:0]                t;
        logic [1:0]                 yy;
        logic [5:0]                 grp;
        logic [emc_pkg::Q400_W+8:0] y400;
        logic [8:0]                 ycent;
        first_len = fl3_reg ? emc_pkg::DAYS_LEAP_YEAR : emc_pkg::DAYS_YEAR;
        t         = '0;
        if (r4_3_reg < first_len) begin
            yy         = 2'd0;
            doy4_next  = r4_3_reg[8:0];
            leap4_next = fl3_reg;
        end else begin
            t          = r4_3_reg - first_len;
            leap4_next = 1'b0;
            if (t < emc_pkg::DAYS_YEAR) begin
                yy        = 2'd1;
                doy4_next = t[8:0];
            end else if (t < {emc_pkg::DAYS_YEAR[9:0], 1'b0}) begin
                yy        = 2'd2;
                doy4_next = 9'(t - emc_pkg::DAYS_YEAR);
            end else begin
                yy        = 2'd3;
                doy4_next = 9'(t - {emc_pkg::DAYS_YEAR[9:0], 1'b0});
            end
        end
        grp        = 6'(q4_3_reg) + 6'(bump3_reg);
        y400       = q400_3_reg * 9'd400;
        ycent      = cent3_reg * 7'd100;
        year4_next = emc_pkg::YEAR_BASE + 12'(y400) + 12'(ycent) + 12'({grp, 2'b00})
                   + 12'(yy);
    end

    // stage 5: month and day
    always_comb begin
        logic [8:0] adj;
        logic [8:0] dsub;
        adj = (leap4_reg && doy4_reg > emc_pkg::LEAP_DAY_DOY) ? doy4_reg - 9'd1 : doy4_reg;
        month5_next = '0;
        for (int i = 1; i < 12; i++) begin
            if (adj >= emc_pkg::month_start(4'(i))) begin
                month5_next = 4'(i);
            end
        end
        dsub      = adj - emc_pkg::month_start(month5_next);
        day5_next = dsub[4:0];
        if (leap4_reg && doy4_reg == emc_pkg::LEAP_DAY_DOY) begin
            month5_next = emc_pkg::MONTH_FEB;
            day5_next   = emc_pkg::LEAP_DAY_INDEX;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[3:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            q400_1_reg <= q400_1_next;
            r1_reg     <= r1_next;
            q400_2_reg <= q400_1_reg;
            cent2_reg  <= cent2_next;
            bump2_reg  <= bump2_next;
            fl2_reg    <= fl2_next;
            u2_reg     <= u2_next;
            q400_3_reg <= q400_2_reg;
            cent3_reg  <= cent2_reg;
            bump3_reg  <= bump2_reg;
            fl3_reg    <= fl2_reg;
            q4_3_reg   <= q4_3_next;
            r4_3_reg   <= r4_3_next;
            year4_reg  <= year4_next;
            doy4_reg   <= doy4_next;
            leap4_reg  <= leap4_next;
            year5_reg  <= year4_reg;
            month5_reg <= month5_next;
            day5_reg   <= day5_next;
        end
    end

    assign out_valid      = valid_reg[4];
    assign out_date.year  = year5_reg;
    assign out_date.month = month5_reg;
    assign out_date.day   = day5_reg;

endmodule

>>> rtl/core/epoch_millis_to_calendar_core.sv
// Top level of the epoch-millis to calendar converter: day split, then
// clock and date pipelines in parallel, then an output skid buffer.
// Depends on emc_pkg, emc_day_split, emc_clock_split, emc_date_split.
//
// Usage:
//   s_tdata carries a millisecond count since 1970-01-01 UTC; values before
//   2000-01-01 are treated as 2000-01-01 00:00:00.000. Bits above TIME_BITS
//   are ignored. Each request yields exactly one result on m_tdata with the
//   Gregorian year, zero-based month and day, hour, minute, second and ms.
//   Throughput is one request per cycle while s_tready is high. Each request
//   passes through five stages of day split (constant division by 84375 via
//   a reciprocal multiply), five stages of clock/date split, and the output
//   register.
//   When m_tready is low the output register holds its result and one more
//   result goes to the skid register; only then does s_tready drop, and the
//   whole pipeline freezes until the skid register drains. Nothing is lost
//   or repeated. Reset (aresetn low at a clock edge) clears all valid bits;
//   no clearing pass is needed and s_tready is high right after reset.
module epoch_millis_to_calendar_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [emc_pkg::S_TDATA_W-1:0]     s_tdata,   // [44:0] epoch_millis
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [11:0] year_full, [15:12] month_index, [20:16] day_index,
    // [25:21] hour_of_day, [31:26] minute_of_hour, [37:32] second_of_minute,
    // [47:38] millisecond_part
    output logic [emc_pkg::M_TDATA_W-1:0]     m_tdata
);

    logic                              pipe_en;
    logic                              split_valid;
    emc_pkg::day_split_t               split;
    logic                              clock_valid;
    emc_pkg::clock_t                   clock_fields;
    logic                              date_valid;
    emc_pkg::date_t                    date_fields;
    logic [emc_pkg::M_TDATA_W-1:0]     result;

    logic                              out_valid_reg;
    logic [emc_pkg::M_TDATA_W-1:0]     out_data_reg;
    logic                              skid_valid_reg;
    logic [emc_pkg::M_TDATA_W-1:0]     skid_data_reg;

    assign pipe_en  = !skid_valid_reg;
    assign s_tready = pipe_en;

    emc_day_split u_day_split (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (pipe_en),
        .in_valid  (s_tvalid),
        .in_millis (s_tdata[emc_pkg::TIME_BITS-1:0]),
        .out_valid (split_valid),
        .out_split (split)
    );

    emc_clock_split u_clock_split (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (pipe_en),
        .in_valid  (split_valid),
        .in_msd    (split.msd),
        .out_valid (clock_valid),
        .out_clock (clock_fields)
    );

    emc_date_split u_date_split (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (pipe_en),
        .in_valid  (split_valid),
        .in_day    (split.day),
        .out_valid (date_valid),
        .out_date  (date_fields)
    );

    assign result = {clock_fields.millis, clock_fields.second, clock_fields.minute,
                     clock_fields.hour, date_fields.day, date_fields.month,
                     date_fields.year};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_tready) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg  <= clock_valid;
            end
        end else if (clock_valid && !skid_valid_reg) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || m_tready) begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : result;
        end else if (!skid_valid_reg) begin
            skid_data_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        clock_valid == date_valid)
        else $error("clock and date pipelines out of step");

    assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register holds a request while output is empty");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[15:12] <= 4'd11 && m_tdata[20:16] <= 5'd30
                      && m_tdata[25:21] <= 5'd23 && m_tdata[31:26] <= 6'd59
                      && m_tdata[37:32] <= 6'd59 && m_tdata[47:38] <= 10'd999))
        else $error("calendar field out of range");

endmodule

>>> tb/tb_epoch_millis_to_calendar_core.sv
`timescale 1ns / 1ps
// Self-checking bench for epoch_millis_to_calendar_core: streams millisecond timestamps and
// compares each calendar result with a built-in Gregorian date predictor.
// Depends on emc_pkg and epoch_millis_to_calendar_core.
module tb_epoch_millis_to_calendar_core;

    localparam int SW = emc_pkg::S_TDATA_W;
    localparam int MW = emc_pkg::M_TDATA_W;
    localparam int RANDOM_REQUESTS = 1900;
    localparam int QUIET_TAIL = 150;
    localparam int STALL_LIMIT = 1000;
    localparam int SETTLE_CYCLES = 20;
    localparam int PRINT_CAP = 40;

    localparam longint unsigned MS_2000 = 64'd946684800000;
    localparam longint unsigned EPOCH_DAYS_2000 = 64'd10957;
    localparam longint unsigned SPAN_400Y = 64'd146097;
    localparam longint unsigned SPAN_100Y = 64'd36524;
    localparam longint unsigned SPAN_4Y = 64'd1461;
    localparam int FEB = 1;
    localparam int MAR = 2;
    localparam int DEC = 11;

    // packed MSB first: millisecond_part sits at the top of m_tdata
    typedef struct packed {
        logic [9:0]  millis;
        logic [5:0]  second;
        logic [5:0]  minute;
        logic [4:0]  hour;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [11:0] year;
    } calendar_t;

    const int unsigned month_first_day [12] =
        '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

    logic          aclk = 1'b0;
    logic          aresetn = 1'b0;
    logic          s_tvalid = 1'b0;
    logic          s_tready;
    logic [SW-1:0] s_tdata = '0;
    logic          m_tvalid;
    logic          m_tready = 1'b0;
    logic [MW-1:0] m_tdata;

    logic [SW-1:0] millis_backlog [$];
    calendar_t     calendar_due [$];
    int            mismatches = 0;
    int            sent_count = 0;
    int            drain_after = -1;
    int            send_gap = 0;
    int            send_idle_pct = 0;
    int            stall_left = 0;
    int            recv_idle_pct = 0;
    int            quiet_cycles = 0;

    epoch_millis_to_calendar_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic bit leap_year(input int y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function automatic longint unsigned leaps_upto(input int y);
        return longint'(y / 4 - y / 100 + y / 400);
    endfunction

    function automatic longint unsigned millis_from_civil(input int y, input int mo, input int dd,
                                                          input int h, input int mi, input int s,
                                                          input int ms);
        longint unsigned days;
        days = 365 * longint'(y - 1970) + leaps_upto(y - 1) - leaps_upto(1969)
             + month_first_day[mo] + ((mo > FEB && leap_year(y)) ? 1 : 0) + dd;
        return (((days * 24 + h) * 60 + mi) * 60 + s) * 1000 + ms;
    endfunction

    function automatic int pick_idle_pct();
        case ($urandom_range(0, 3))
            0: return 0;
            1: return 10;
            2: return 35;
            default: return 70;
        endcase
    endfunction

    function automatic calendar_t civil_from_millis(input logic [SW-1:0] raw);
        longint unsigned v, d, r, r4, t, doy, yy, year, first_len;
        bit lead_leap, leap;
        int mon;
        calendar_t res;
        v = 64'(raw[emc_pkg::TIME_BITS-1:0]);
        if (v < MS_2000)
            v = MS_2000;
        res.millis = 10'(v % 1000);
        v = v / 1000;
        res.second = 6'(v % 60);
        v = v / 60;
        res.minute = 6'(v % 60);
        v = v / 60;
        res.hour = 5'(v % 24);
        d = v / 24 - EPOCH_DAYS_2000;

        year = 400 * (d / SPAN_400Y);
        r = d % SPAN_400Y;
        if (r < SPAN_100Y + 1) begin
            year += (r / SPAN_4Y) * 4;
            r4 = r % SPAN_4Y;
            lead_leap = 1'b1;
        end else begin
            t = r - (SPAN_100Y + 1);
            year += 100 * (1 + t / SPAN_100Y);
            r = t % SPAN_100Y;
            // common century year: first 4-year group is one day short
            if (r < SPAN_4Y - 1) begin
                r4 = r;
                lead_leap = 1'b0;
            end else begin
                t = r - (SPAN_4Y - 1);
                year += 4 * (1 + t / SPAN_4Y);
                r4 = t % SPAN_4Y;
                lead_leap = 1'b1;
            end
        end

        first_len = lead_leap ? 366 : 365;
        if (r4 < first_len) begin
            doy = r4;
            leap = lead_leap;
        end else begin
            t = r4 - first_len;
            yy = 1 + t / 365;
            if (yy > 3)
                yy = 3;
            doy = t - (yy - 1) * 365;
            year += yy;
            leap = 1'b0;
        end
        res.year = 12'(year + 2000);

        if (leap && doy == 59) begin
            mon = FEB;
            res.day = 5'd28;
        end else begin
            if (leap && doy > 59)
                doy = doy - 1;
            mon = 0;
            for (int i = 1; i < 12; i++) begin
                if (doy >= month_first_day[i])
                    mon = i;
            end
            res.day = 5'(doy - month_first_day[mon]);
        end
        res.month = 4'(mon);
        return res;
    endfunction

    task automatic report_field(input string what, input longint unsigned got,
                                input longint unsigned want);
        if (mismatches < PRINT_CAP)
            $display("ERROR %0t %s: got %0d expected %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    // request side
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                calendar_due.push_back(civil_from_millis(s_tdata));
                sent_count++;
                if (sent_count % 128 == 0)
                    send_idle_pct = pick_idle_pct();
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (sent_count == drain_after && calendar_due.size() != 0) begin
                    s_tvalid <= 1'b0;
                end else if (millis_backlog.size() != 0) begin
                    s_tvalid <= 1'b1;
                    s_tdata <= millis_backlog.pop_front();
                    if (millis_backlog.size() >= QUIET_TAIL
                            && $urandom_range(0, 99) < send_idle_pct)
                        send_gap = $urandom_range(1, 5);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result side
    always @(posedge aclk) begin
        calendar_t got, want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (calendar_due.size() == 0) begin
                    report_field("unexpected result, year", 64'(got.year), 64'd0);
                end else begin
                    want = calendar_due.pop_front();
                    if (got.year !== want.year)
                        report_field("year", 64'(got.year), 64'(want.year));
                    if (got.month !== want.month)
                        report_field("month", 64'(got.month), 64'(want.month));
                    if (got.day !== want.day)
                        report_field("day", 64'(got.day), 64'(want.day));
                    if (got.hour !== want.hour)
                        report_field("hour", 64'(got.hour), 64'(want.hour));
                    if (got.minute !== want.minute)
                        report_field("minute", 64'(got.minute), 64'(want.minute));
                    if (got.second !== want.second)
                        report_field("second", 64'(got.second), 64'(want.second));
                    if (got.millis !== want.millis)
                        report_field("millis", 64'(got.millis), 64'(want.millis));
                end
                if ($urandom_range(0, 127) == 0)
                    recv_idle_pct = pick_idle_pct();
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (millis_backlog.size() >= QUIET_TAIL
                         && $urandom_range(0, 99) < recv_idle_pct) begin
                stall_left = $urandom_range(0, 4);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("epoch_millis_to_calendar_core: mismatch");
                $finish;
            end
        end
    end

    initial begin
        longint unsigned v;
        logic [SW-1:0] raw;
        int y, mo, dd, h, mi, s, ms, len, kind;

        // directed: range edges, masking, leap days, century years, block ends
        millis_backlog.push_back('0);
        millis_backlog.push_back(SW'(MS_2000 - 1));
        millis_backlog.push_back(SW'(MS_2000));
        millis_backlog.push_back(SW'({emc_pkg::TIME_BITS{1'b1}}));
        millis_backlog.push_back({SW{1'b1}});
        millis_backlog.push_back({1'b1, {(SW - 1){1'b0}}} | SW'(MS_2000 + 1));
        millis_backlog.push_back(SW'(millis_from_civil(2000, FEB, 28, 12, 30, 30, 500)));
        millis_backlog.push_back(SW'(millis_from_civil(2000, FEB, 27, 23, 59, 59, 999)));
        millis_backlog.push_back(SW'(millis_from_civil(2000, MAR, 0, 0, 0, 0, 0)));
        millis_backlog.push_back(SW'(millis_from_civil(2000, DEC, 30, 23, 59, 59, 999)));
        millis_backlog.push_back(SW'(millis_from_civil(2001, 0, 0, 0, 0, 0, 0)));
        millis_backlog.push_back(SW'(millis_from_civil(2003, DEC, 30, 23, 59, 59, 999)));
        millis_backlog.push_back(SW'(millis_from_civil(2004, FEB, 28, 7, 7, 7, 7)));
        millis_backlog.push_back(SW'(millis_from_civil(2096, FEB, 28, 1, 2, 3, 4)));
        millis_backlog.push_back(SW'(millis_from_civil(2100, FEB, 27, 23, 59, 59, 999)));
        millis_backlog.push_back(SW'(millis_from_civil(2100, MAR, 0, 0, 0, 0, 0)));
        millis_backlog.push_back(SW'(millis_from_civil(2100, DEC, 30, 23, 59, 59, 999)));
        millis_backlog.push_back(SW'(millis_from_civil(2101, 0, 0, 0, 0, 0, 0)));
        millis_backlog.push_back(SW'(millis_from_civil(2104, FEB, 28, 0, 0, 0, 0)));
        millis_backlog.push_back(SW'(millis_from_civil(2200, MAR, 0, 0, 0, 0, 0)));
        millis_backlog.push_back(SW'(millis_from_civil(2300, FEB, 27, 23, 59, 59, 999)));
        millis_backlog.push_back(SW'(millis_from_civil(2399, DEC, 30, 23, 59, 59, 999)));
        millis_backlog.push_back(SW'(millis_from_civil(2400, FEB, 28, 0, 0, 0, 0)));
        millis_backlog.push_back(SW'(millis_from_civil(2400, DEC, 30, 23, 59, 59, 999)));
        millis_backlog.push_back(SW'(millis_from_civil(2401, 0, 0, 0, 0, 0, 0)));
        drain_after = millis_backlog.size();

        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            kind = $urandom_range(0, 99);
            if (kind < 60) begin
                if (kind < 35) begin
                    y = $urandom_range(2000, 3083);
                    mo = $urandom_range(0, DEC);
                    len = (mo == DEC) ? 31 : month_first_day[mo + 1] - month_first_day[mo];
                    if (mo == FEB && leap_year(y))
                        len++;
                    dd = $urandom_range(0, len - 1);
                end else begin
                    y = $urandom_range(0, 1) ? $urandom_range(2000, 3083)
                                             : 1999 + 100 * $urandom_range(0, 10)
                                               + $urandom_range(0, 5);
                    if (y < 2000)
                        y = 2000;
                    case ($urandom_range(0, 4))
                        0: begin mo = FEB; dd = 27; end
                        1: begin mo = FEB; dd = leap_year(y) ? 28 : 27; end
                        2: begin mo = MAR; dd = 0; end
                        3: begin mo = DEC; dd = 30; end
                        default: begin mo = 0; dd = 0; end
                    endcase
                end
                case ($urandom_range(0, 2))
                    0: begin h = 0; mi = 0; s = 0; ms = 0; end
                    1: begin h = 23; mi = 59; s = 59; ms = 999; end
                    default: begin
                        h = $urandom_range(0, 23);
                        mi = $urandom_range(0, 59);
                        s = $urandom_range(0, 59);
                        ms = $urandom_range(0, 999);
                    end
                endcase
                v = millis_from_civil(y, mo, dd, h, mi, s, ms);
            end else if (kind < 88) begin
                v = {$urandom, $urandom};
            end else begin
                v = {$urandom, $urandom} % MS_2000;
            end
            raw = SW'({$urandom, $urandom});
            raw[emc_pkg::TIME_BITS-1:0] = v[emc_pkg::TIME_BITS-1:0];
            millis_backlog.push_back(raw);
        end

        send_idle_pct = pick_idle_pct();
        recv_idle_pct = pick_idle_pct();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        while (millis_backlog.size() != 0 || s_tvalid)
            @(posedge aclk);
        while (calendar_due.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (mismatches == 0)
            $display("epoch_millis_to_calendar_core: match");
        else
            $display("epoch_millis_to_calendar_core: mismatch");
        $finish;
    end

endmodule
